// ----- sv/rime_pkg.sv -----
// Shared types and constants for the RGBA image merge engine.
package rime_pkg;

  localparam int PIXEL_W     = 32;
  localparam int CHAN_W      = 8;
  localparam int COUNT_W     = 5;
  localparam int SIDE_W      = 11;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;

  typedef enum logic [1:0] {
    MODE_OVERWRITE = 2'd0,
    MODE_ALPHA     = 2'd1,
    MODE_MASK      = 2'd2,
    MODE_TILE      = 2'd3
  } merge_mode_t;

  localparam logic CMD_SCAN  = 1'b0;
  localparam logic CMD_MERGE = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] CFG_MERGE_MODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILES_ACROSS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILES_DOWN   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_WIDTH   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_HEIGHT  = 3'd4;

  localparam merge_mode_t        RST_MERGE_MODE   = MODE_ALPHA;
  localparam logic [COUNT_W-1:0] RST_TILES_ACROSS = 5'd1;
  localparam logic [COUNT_W-1:0] RST_TILES_DOWN   = 5'd1;
  localparam logic [SIDE_W-1:0]  RST_TILE_WIDTH   = 11'd16;
  localparam logic [SIDE_W-1:0]  RST_TILE_HEIGHT  = 11'd16;

  typedef struct packed {
    merge_mode_t        mode;
    logic [COUNT_W-1:0] tiles_across;
    logic [COUNT_W-1:0] tiles_down;
    logic [SIDE_W-1:0]  tile_width;
    logic [SIDE_W-1:0]  tile_height;
  } cfg_t;

  // What the raster tracker knows about the pixel currently being processed
  typedef struct packed {
    logic ok;
    logic marked;
    logic last;
  } tile_info_t;

endpackage

// ----- sv/rime_raster.sv -----
// Raster position counters, geometry check and per-tile mark flags.
module rime_raster
  import rime_pkg::*;
#(
  parameter int MAX_TILES_ACROSS = 16,
  parameter int MAX_TILES_DOWN   = 16,
  parameter int MAX_TILE_SIDE    = 1024
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic       scan,
  input  logic       src_visible,
  output tile_info_t info
);

  localparam int COL_W      = (MAX_TILE_SIDE > 1) ? $clog2(MAX_TILE_SIDE) : 1;
  localparam int TCOL_W     = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;
  localparam int TROW_W     = (MAX_TILES_DOWN > 1) ? $clog2(MAX_TILES_DOWN) : 1;
  localparam int MARK_COUNT = MAX_TILES_ACROSS * MAX_TILES_DOWN;
  localparam int SLOT_W     = (MARK_COUNT > 1) ? $clog2(MARK_COUNT) : 1;
  localparam int BSUM_W     = SLOT_W + COUNT_W;

  logic [COL_W-1:0]      column_in_tile, column_in_tile_next;
  logic [COL_W-1:0]      row_in_tile, row_in_tile_next;
  logic [TCOL_W-1:0]     tile_column, tile_column_next;
  logic [TROW_W-1:0]     tile_row, tile_row_next;
  logic [SLOT_W-1:0]     tile_row_base, tile_row_base_next;
  logic [MARK_COUNT-1:0] tile_marks, tile_marks_next;

  logic [COL_W:0]    col_inc, row_inc;
  logic [TCOL_W:0]   tcol_inc;
  logic [TROW_W:0]   trow_inc;
  logic [BSUM_W-1:0] base_sum;
  logic [SLOT_W:0]   slot;
  logic [SLOT_W-1:0] slot_idx;
  logic              slot_in_range;
  logic              geom_ok;
  logic              at_origin;
  logic              at_last;

  always_comb begin
    col_inc  = {1'b0, column_in_tile} + (COL_W+1)'(1);
    row_inc  = {1'b0, row_in_tile} + (COL_W+1)'(1);
    tcol_inc = {1'b0, tile_column} + (TCOL_W+1)'(1);
    trow_inc = {1'b0, tile_row} + (TROW_W+1)'(1);
    base_sum = BSUM_W'(tile_row_base) + BSUM_W'(cfg.tiles_across);
    slot     = (SLOT_W+1)'(tile_row_base) + (SLOT_W+1)'(tile_column);
    slot_idx = slot[SLOT_W-1:0];
    slot_in_range = 32'(slot) < 32'(MARK_COUNT);

    geom_ok = (cfg.tiles_across != '0) && (32'(cfg.tiles_across) <= 32'(MAX_TILES_ACROSS)) &&
              (cfg.tiles_down != '0) && (32'(cfg.tiles_down) <= 32'(MAX_TILES_DOWN)) &&
              (cfg.tile_width != '0) && (32'(cfg.tile_width) <= 32'(MAX_TILE_SIDE)) &&
              (cfg.tile_height != '0) && (32'(cfg.tile_height) <= 32'(MAX_TILE_SIDE));

    at_origin = (column_in_tile == '0) && (row_in_tile == '0) &&
                (tile_column == '0) && (tile_row == '0);

    at_last = (32'(col_inc) >= 32'(cfg.tile_width)) &&
              (32'(tcol_inc) >= 32'(cfg.tiles_across)) &&
              (32'(row_inc) >= 32'(cfg.tile_height)) &&
              (32'(trow_inc) >= 32'(cfg.tiles_down));

    info.ok     = geom_ok;
    info.marked = slot_in_range && tile_marks[slot_idx];
    info.last   = at_last;

    column_in_tile_next = column_in_tile;
    row_in_tile_next    = row_in_tile;
    tile_column_next    = tile_column;
    tile_row_next       = tile_row;
    tile_row_base_next  = tile_row_base;
    tile_marks_next     = tile_marks;

    if (step && geom_ok) begin
      // carry ripples pixel -> tile column -> row -> tile row
      if (32'(col_inc) < 32'(cfg.tile_width)) begin
        column_in_tile_next = col_inc[COL_W-1:0];
      end else begin
        column_in_tile_next = '0;
        if (32'(tcol_inc) < 32'(cfg.tiles_across)) begin
          tile_column_next = tcol_inc[TCOL_W-1:0];
        end else begin
          tile_column_next = '0;
          if (32'(row_inc) < 32'(cfg.tile_height)) begin
            row_in_tile_next = row_inc[COL_W-1:0];
          end else begin
            row_in_tile_next = '0;
            if ((32'(trow_inc) < 32'(cfg.tiles_down)) &&
                (32'(base_sum) < 32'(MARK_COUNT))) begin
              tile_row_next      = trow_inc[TROW_W-1:0];
              tile_row_base_next = base_sum[SLOT_W-1:0];
            end else begin
              tile_row_next      = '0;
              tile_row_base_next = '0;
            end
          end
        end
      end

      if (scan) begin
        if (at_origin) begin
          tile_marks_next = '0;
        end
        if (src_visible && slot_in_range) begin
          tile_marks_next[slot_idx] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_in_tile <= '0;
      row_in_tile    <= '0;
      tile_column    <= '0;
      tile_row       <= '0;
      tile_row_base  <= '0;
      tile_marks     <= '0;
    end else begin
      column_in_tile <= column_in_tile_next;
      row_in_tile    <= row_in_tile_next;
      tile_column    <= tile_column_next;
      tile_row       <= tile_row_next;
      tile_row_base  <= tile_row_base_next;
      tile_marks     <= tile_marks_next;
    end
  end

endmodule

// ----- sv/rime_merge.sv -----
// Per-pixel merge datapath: mode select, mask blend lanes and tile rules.
module rime_merge
  import rime_pkg::*;
(
  input  merge_mode_t        mode,
  input  tile_info_t         info,
  input  logic [PIXEL_W-1:0] dest_px,
  input  logic [PIXEL_W-1:0] src_px,
  input  logic [PIXEL_W-1:0] mask_px,
  output logic [PIXEL_W-1:0] merged_px,
  output logic               cleared,
  output logic               fend,
  output logic               stat
);

  localparam int LANES = PIXEL_W / CHAN_W;

  logic [PIXEL_W-1:0] blend_px;
  logic               src_visible;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    logic [CHAN_W-1:0] sc, dc, mc;
    logic [15:0]       acc;
    logic [15:0]       quo;

    always_comb begin
      sc  = src_px[g*CHAN_W +: CHAN_W];
      dc  = dest_px[g*CHAN_W +: CHAN_W];
      mc  = mask_px[g*CHAN_W +: CHAN_W];
      acc = 16'(sc) * 16'(mc) + 16'(dc) * 16'(8'd255 - mc);
      // exact floor(acc/255) for acc up to 255*255
      quo = acc + 16'd1 + 16'(acc[15:8]);
      blend_px[g*CHAN_W +: CHAN_W] = quo[15:8];
    end
  end

  always_comb begin
    src_visible = src_px[31:24] != '0;
    merged_px   = dest_px;
    cleared     = 1'b0;
    stat        = 1'b0;
    case (mode)
      MODE_OVERWRITE: merged_px = src_px;
      MODE_ALPHA:     merged_px = src_visible ? src_px : dest_px;
      MODE_MASK:      merged_px = blend_px;
      MODE_TILE: begin
        if (!info.ok) begin
          stat = 1'b1;
        end else begin
          cleared   = info.marked;
          merged_px = src_visible ? src_px : (info.marked ? '0 : dest_px);
        end
      end
      default:        merged_px = dest_px;
    endcase
    fend = info.ok && info.last;
  end

endmodule

// ----- sv/rgba_image_merge_engine_core.sv -----
// Top level of the RGBA image merge engine: registers, handshakes and stage wiring.
//
// Pixels stream in raster order on the input channel (in_valid/in_ready) with
// cmd, dest_pixel, src_pixel and mask_pixel. cmd 0 is a scan beat that only
// updates the tile marks; cmd 1 is a merge beat that yields one result beat on
// the output channel (out_valid/out_ready) carrying merged_pixel,
// in_cleared_tile, frame_end and status. Both kinds of beat advance the raster
// position. Registers are written on the cfg channel (cfg_index, cfg_data),
// which is always ready; write them only while the engine is idle.
// A merge beat is captured in the input register and its result in the result
// register. Throughput: one beat per cycle while results are taken, set by the
// single input register and single result register with the merge logic between
// them. When the receiver stalls, the result holds and the input register keeps
// taking one more beat; scan beats keep draining since they make no result.
// Reset clears the position, all tile marks and both stages, and loads the
// register defaults: alpha threshold, one 16x16 tile.
module rgba_image_merge_engine_core
  import rime_pkg::*;
#(
  parameter int MAX_TILES_ACROSS = 16,
  parameter int MAX_TILES_DOWN   = 16,
  parameter int MAX_TILE_SIDE    = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   cmd,
  input  logic [PIXEL_W-1:0]     dest_pixel,
  input  logic [PIXEL_W-1:0]     src_pixel,
  input  logic [PIXEL_W-1:0]     mask_pixel,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PIXEL_W-1:0]     merged_pixel,
  output logic                   in_cleared_tile,
  output logic                   frame_end,
  output logic                   status
);

  cfg_t cfg;

  logic               in_full;
  logic               cmd_r;
  logic [PIXEL_W-1:0] dest_r, src_r, mask_r;

  logic               out_free;
  logic               fire;
  tile_info_t         info;
  logic [PIXEL_W-1:0] merged_px;
  logic               cleared, fend, stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= RST_MERGE_MODE;
      cfg.tiles_across <= RST_TILES_ACROSS;
      cfg.tiles_down   <= RST_TILES_DOWN;
      cfg.tile_width   <= RST_TILE_WIDTH;
      cfg.tile_height  <= RST_TILE_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MERGE_MODE:   cfg.mode         <= merge_mode_t'(cfg_data[1:0]);
        CFG_TILES_ACROSS: cfg.tiles_across <= cfg_data[COUNT_W-1:0];
        CFG_TILES_DOWN:   cfg.tiles_down   <= cfg_data[COUNT_W-1:0];
        CFG_TILE_WIDTH:   cfg.tile_width   <= cfg_data[SIDE_W-1:0];
        CFG_TILE_HEIGHT:  cfg.tile_height  <= cfg_data[SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // scan beats never wait on the output side
  assign out_free = !out_valid || out_ready;
  assign fire     = in_full && ((cmd_r == CMD_SCAN) || out_free);
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= cmd;
      dest_r <= dest_pixel;
      src_r  <= src_pixel;
      mask_r <= mask_pixel;
    end
  end

  rime_raster #(
    .MAX_TILES_ACROSS(MAX_TILES_ACROSS),
    .MAX_TILES_DOWN  (MAX_TILES_DOWN),
    .MAX_TILE_SIDE   (MAX_TILE_SIDE)
  ) u_raster (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step       (fire),
    .scan       (cmd_r == CMD_SCAN),
    .src_visible(src_r[31:24] != '0),
    .info       (info)
  );

  rime_merge u_merge (
    .mode     (cfg.mode),
    .info     (info),
    .dest_px  (dest_r),
    .src_px   (src_r),
    .mask_px  (mask_r),
    .merged_px(merged_px),
    .cleared  (cleared),
    .fend     (fend),
    .stat     (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && (cmd_r == CMD_MERGE)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (cmd_r == CMD_MERGE)) begin
      merged_pixel    <= merged_px;
      in_cleared_tile <= cleared;
      frame_end       <= fend;
      status          <= stat;
    end
  end

endmodule

// ----- sv/rime_checker.sv -----
// Port-level checks for the merge engine core, bound to the top level.
module rime_checker
  import rime_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [PIXEL_W-1:0] merged_pixel,
  input logic               in_cleared_tile,
  input logic               frame_end,
  input logic               status
);

  // a stalled result beat must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(merged_pixel) && $stable(status))
    else $error("result beat changed while stalled");

  // a fresh result needs an earlier accepted input beat
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without a matching input beat");

  // bad geometry never advances, so never ends a frame
  a_status_no_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> !frame_end && !in_cleared_tile)
    else $error("geometry error beat flagged frame end or marked tile");

  // inside a marked tile the pixel is either the visible source or transparent black
  a_cleared_px: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_cleared_tile |-> (merged_pixel == '0) || (merged_pixel[31:24] != '0))
    else $error("marked tile pixel is neither source nor transparent black");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present straight after reset");

endmodule

bind rgba_image_merge_engine_core rime_checker u_rime_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .merged_pixel   (merged_pixel),
  .in_cleared_tile(in_cleared_tile),
  .frame_end      (frame_end),
  .status         (status)
);

// ----- verif/testbench.sv -----
// Self-checking testbench for the RGBA image merge engine: directed plan, then random frames.
module testbench;
  import rime_pkg::*;

  localparam int MAX_ACROSS     = 16;
  localparam int MAX_DOWN       = 16;
  localparam int MAX_SIDE       = 1024;
  localparam int TILE_SLOTS     = MAX_ACROSS * MAX_DOWN;
  localparam int SETTLE_CYCLES  = 4;
  localparam int BEAT_BUDGET    = 1275;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int FRAME_CAP      = 256;
  // indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [PIXEL_W-1:0] merged;
    logic               cleared;
    logic               fend;
    logic               status;
  } pixel_result_t;

  typedef struct packed {
    bit                     is_reg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  val;
    logic                   c;
    logic [PIXEL_W-1:0]     dst;
    logic [PIXEL_W-1:0]     src;
    logic [PIXEL_W-1:0]     msk;
    bit                     typed;
    pixel_result_t          hand;
  } plan_row_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic cmd = 1'b0;
  logic [PIXEL_W-1:0] dest_pixel = '0;
  logic [PIXEL_W-1:0] src_pixel = '0;
  logic [PIXEL_W-1:0] mask_pixel = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PIXEL_W-1:0] merged_pixel;
  logic in_cleared_tile;
  logic frame_end;
  logic status;

  rgba_image_merge_engine_core #(
    .MAX_TILES_ACROSS(MAX_ACROSS),
    .MAX_TILES_DOWN(MAX_DOWN),
    .MAX_TILE_SIDE(MAX_SIDE)
  ) dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .dest_pixel(dest_pixel),
    .src_pixel(src_pixel), .mask_pixel(mask_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .merged_pixel(merged_pixel),
    .in_cleared_tile(in_cleared_tile), .frame_end(frame_end), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // register shadow and raster position of the predictor
  merge_mode_t        cur_mode    = RST_MERGE_MODE;
  logic [COUNT_W-1:0] cur_across  = RST_TILES_ACROSS;
  logic [COUNT_W-1:0] cur_down    = RST_TILES_DOWN;
  logic [SIDE_W-1:0]  cur_twidth  = RST_TILE_WIDTH;
  logic [SIDE_W-1:0]  cur_theight = RST_TILE_HEIGHT;
  int unsigned col_in = 0, row_in = 0, tcol = 0, trow = 0, row_base = 0;
  bit tile_marks [TILE_SLOTS];

  pixel_result_t merges_due [$];
  plan_row_t     plan [$];
  pixel_result_t want;

  int unsigned errors = 0, pixels_sent = 0, results_seen = 0, frame_ends = 0;
  int unsigned marked_hits = 0, writes = 0, phases = 0, quiet = 0;
  int unsigned stall_left = 0, mood_left = 0;
  bit rx_calm = 1'b0, tx_calm = 1'b0;

  function automatic bit geom_valid();
    return cur_across != 0 && cur_across <= MAX_ACROSS && cur_down != 0 &&
           cur_down <= MAX_DOWN && cur_twidth != 0 && cur_twidth <= MAX_SIDE &&
           cur_theight != 0 && cur_theight <= MAX_SIDE;
  endfunction

  function automatic bit at_frame_origin();
    return col_in == 0 && row_in == 0 && tcol == 0 && trow == 0;
  endfunction

  function automatic bit at_frame_last();
    return col_in + 1 >= cur_twidth && tcol + 1 >= cur_across &&
           row_in + 1 >= cur_theight && trow + 1 >= cur_down;
  endfunction

  // counters above a freshly written limit wrap on the next advance
  function automatic void step_raster();
    col_in++;
    if (col_in < cur_twidth) return;
    col_in = 0;
    tcol++;
    if (tcol < cur_across) return;
    tcol = 0;
    row_in++;
    if (row_in < cur_theight) return;
    row_in = 0;
    trow++;
    row_base += cur_across;
    if (trow < cur_down && row_base < TILE_SLOTS) return;
    trow = 0;
    row_base = 0;
  endfunction

  function automatic logic [PIXEL_W-1:0] blend_channels(input logic [PIXEL_W-1:0] s, d, m);
    logic [PIXEL_W-1:0] r;
    int unsigned sc, dc, mc, v;
    r = '0;
    for (int ch = 0; ch < 4; ch++) begin
      sc = s[ch*CHAN_W +: CHAN_W];
      dc = d[ch*CHAN_W +: CHAN_W];
      mc = m[ch*CHAN_W +: CHAN_W];
      v = (sc * mc + dc * (255 - mc)) / 255;
      r[ch*CHAN_W +: CHAN_W] = v[CHAN_W-1:0];
    end
    return r;
  endfunction

  // Works out the result of one pixel beat and moves the predictor on; 0 for a scan.
  function automatic bit predict_pixel(input logic c, input logic [PIXEL_W-1:0] dst, src, msk,
                                       output pixel_result_t res);
    bit ok, vis, marked;
    int unsigned slot;
    ok = geom_valid();
    vis = src[31:24] != 8'h00;
    slot = row_base + tcol;
    marked = (slot < TILE_SLOTS) ? tile_marks[slot] : 1'b0;
    res.merged = dst;
    res.cleared = 1'b0;
    res.fend = 1'b0;
    res.status = 1'b0;
    if (c == CMD_SCAN) begin
      if (ok) begin
        if (at_frame_origin()) foreach (tile_marks[k]) tile_marks[k] = 1'b0;
        if (vis && slot < TILE_SLOTS) tile_marks[slot] = 1'b1;
        step_raster();
      end
      return 1'b0;
    end
    case (cur_mode)
      MODE_OVERWRITE: res.merged = src;
      MODE_ALPHA:     res.merged = vis ? src : dst;
      MODE_MASK:      res.merged = blend_channels(src, dst, msk);
      default: begin
        if (!ok) begin
          res.status = 1'b1;
        end else begin
          res.cleared = marked;
          res.merged = vis ? src : (marked ? '0 : dst);
        end
      end
    endcase
    if (ok) begin
      res.fend = at_frame_last();
      step_raster();
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [PIXEL_W-1:0] got,
                                 input logic [PIXEL_W-1:0] exp_val);
    $display("mismatch: %s got %h expected %h at %0t", what, got, exp_val, $time);
    errors++;
  endtask

  function automatic void row_reg(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.val = val;
    plan.push_back(r);
  endfunction

  function automatic void row_pix(input logic c, input logic [PIXEL_W-1:0] dst, src, msk,
                                  input bit typed, input logic [PIXEL_W-1:0] px,
                                  input logic clr, fe, st);
    plan_row_t r;
    r = '0;
    r.c = c;
    r.dst = dst;
    r.src = src;
    r.msk = msk;
    r.typed = typed;
    r.hand.merged = px;
    r.hand.cleared = clr;
    r.hand.fend = fe;
    r.hand.status = st;
    plan.push_back(r);
  endfunction

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MERGE_MODE:   cur_mode = merge_mode_t'(val[1:0]);
      CFG_TILES_ACROSS: cur_across = val[COUNT_W-1:0];
      CFG_TILES_DOWN:   cur_down = val[COUNT_W-1:0];
      CFG_TILE_WIDTH:   cur_twidth = val;
      CFG_TILE_HEIGHT:  cur_theight = val;
      default: ;
    endcase
    writes++;
  endtask

  task automatic push_pixel(input logic c, input logic [PIXEL_W-1:0] dst, src, msk,
                            input bit typed, input pixel_result_t hand);
    int unsigned gap, roll;
    pixel_result_t res;
    cfg_valid <= 1'b0;
    roll = $urandom_range(0, 19);
    if (tx_calm || roll < 12) gap = 0;
    else if (roll < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(5, 20);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    dest_pixel <= dst;
    src_pixel <= src;
    mask_pixel <= msk;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // scans under bad geometry are dropped by the block and not counted
    if (c == CMD_MERGE || geom_valid()) pixels_sent++;
    if (predict_pixel(c, dst, src, msk, res)) merges_due.push_back(typed ? hand : res);
  endtask

  // idle the input and let the pipe empty before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    while (merges_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stalls, mostly short, with calm stretches
  always @(posedge clk) begin
    if (mood_left == 0) begin
      rx_calm <= ($urandom_range(0, 2) == 0);
      mood_left <= $urandom_range(40, 300);
    end else begin
      mood_left <= mood_left - 1;
    end
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (rx_calm || $urandom_range(0, 3) != 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (merges_due.size() == 0) begin
        report_mismatch("result beat with nothing pending", merged_pixel, '0);
      end else begin
        want = merges_due.pop_front();
        results_seen++;
        if (want.fend) frame_ends++;
        if (want.cleared) marked_hits++;
        if (merged_pixel !== want.merged)
          report_mismatch("merged_pixel", merged_pixel, want.merged);
        if (in_cleared_tile !== want.cleared)
          report_mismatch("in_cleared_tile", in_cleared_tile, want.cleared);
        if (frame_end !== want.fend) report_mismatch("frame_end", frame_end, want.fend);
        if (status !== want.status) report_mismatch("status", status, want.status);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet == WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    merge_mode_t mode_pick;
    logic [COUNT_W-1:0] g_across, g_down;
    logic [SIDE_W-1:0] g_width, g_height;
    logic [PIXEL_W-1:0] junk, src;
    int unsigned shape, npix, n;
    bit broken;

    foreach (tile_marks[k]) tile_marks[k] = 1'b0;

    // 2x2 frame of 1x1 tiles: scan marks tile 1 only, then merge reads the marks
    row_reg(CFG_MERGE_MODE, MODE_TILE);
    row_reg(CFG_TILES_ACROSS, 11'd2);
    row_reg(CFG_TILES_DOWN, 11'd2);
    row_reg(CFG_TILE_WIDTH, 11'd1);
    row_reg(CFG_TILE_HEIGHT, 11'd1);
    row_pix(CMD_SCAN, 32'h0, 32'h00FF_FFFF, 32'h0, 0, 32'h0, 0, 0, 0);
    row_pix(CMD_SCAN, 32'h0, 32'hFF00_0000, 32'h0, 0, 32'h0, 0, 0, 0);
    row_pix(CMD_SCAN, 32'h0, 32'h0000_0000, 32'h0, 0, 32'h0, 0, 0, 0);
    row_pix(CMD_SCAN, 32'h0, 32'h0012_3456, 32'h0, 0, 32'h0, 0, 0, 0);
    row_pix(CMD_MERGE, 32'h1111_1111, 32'h00FF_FFFF, 32'h0, 1, 32'h1111_1111, 0, 0, 0);
    row_pix(CMD_MERGE, 32'h2222_2222, 32'h00FF_FFFF, 32'h0, 1, 32'h0000_0000, 1, 0, 0);
    row_pix(CMD_MERGE, 32'h3333_3333, 32'h80AB_CDEF, 32'h0, 1, 32'h80AB_CDEF, 0, 0, 0);
    row_pix(CMD_MERGE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 1, 32'hFFFF_FFFF, 0, 1, 0);
    // scan at the origin wipes the marks again
    row_pix(CMD_SCAN, 32'h0, 32'h00FF_FFFF, 32'h0, 0, 32'h0, 0, 0, 0);
    row_pix(CMD_MERGE, 32'h4444_4444, 32'h0000_0000, 32'h0, 1, 32'h4444_4444, 0, 0, 0);
    row_reg(CFG_MERGE_MODE, MODE_ALPHA);
    row_pix(CMD_MERGE, 32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h0, 1, 32'hFFFF_FFFF, 0, 0, 0);
    row_pix(CMD_MERGE, 32'h0000_0000, 32'hFF00_0000, 32'h0, 1, 32'hFF00_0000, 0, 1, 0);
    row_reg(CFG_MERGE_MODE, MODE_OVERWRITE);
    row_pix(CMD_MERGE, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1, 32'h0, 0, 0, 0);
    row_reg(CFG_MERGE_MODE, MODE_MASK);
    row_pix(CMD_MERGE, 32'h9ABC_DEF0, 32'h1234_5678, 32'hFFFF_FFFF, 1, 32'h1234_5678, 0, 0, 0);
    row_pix(CMD_MERGE, 32'h9ABC_DEF0, 32'h1234_5678, 32'h0000_0000, 1, 32'h9ABC_DEF0, 0, 0, 0);
    row_pix(CMD_MERGE, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0101_0101, 0, 32'h0, 0, 0, 0);
    // each kind of bad geometry: destination through, status set
    row_reg(CFG_MERGE_MODE, MODE_TILE);
    row_reg(CFG_TILE_WIDTH, 11'd0);
    row_pix(CMD_MERGE, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 32'h0, 1, 32'hA5A5_A5A5, 0, 0, 1);
    row_pix(CMD_SCAN, 32'h0, 32'hFF00_0000, 32'h0, 0, 32'h0, 0, 0, 0);
    row_reg(CFG_TILE_WIDTH, 11'd2047);
    row_pix(CMD_MERGE, 32'h5A5A_5A5A, 32'h0000_0000, 32'h0, 1, 32'h5A5A_5A5A, 0, 0, 1);
    row_reg(CFG_TILE_WIDTH, 11'd1);
    row_reg(CFG_TILES_ACROSS, 11'd0);
    row_pix(CMD_MERGE, 32'hC3C3_C3C3, 32'hFF00_FF00, 32'h0, 1, 32'hC3C3_C3C3, 0, 0, 1);
    row_reg(CFG_TILES_ACROSS, 11'd31);
    row_pix(CMD_MERGE, 32'h3C3C_3C3C, 32'hFF00_FF00, 32'h0, 1, 32'h3C3C_3C3C, 0, 0, 1);
    row_reg(CFG_TILES_ACROSS, 11'd16);
    row_reg(CFG_TILES_DOWN, 11'd0);
    row_pix(CMD_MERGE, 32'h0F0F_0F0F, 32'hFF00_FF00, 32'h0, 1, 32'h0F0F_0F0F, 0, 0, 1);
    row_reg(CFG_TILES_DOWN, 11'd17);
    row_pix(CMD_MERGE, 32'hF0F0_F0F0, 32'hFF00_FF00, 32'h0, 1, 32'hF0F0_F0F0, 0, 0, 1);
    row_reg(CFG_TILES_DOWN, 11'd1);
    row_reg(CFG_TILE_HEIGHT, 11'd0);
    row_pix(CMD_MERGE, 32'h9696_9696, 32'hFF00_FF00, 32'h0, 1, 32'h9696_9696, 0, 0, 1);
    row_reg(CFG_TILE_HEIGHT, 11'd1025);
    row_pix(CMD_MERGE, 32'h6969_6969, 32'hFF00_FF00, 32'h0, 1, 32'h6969_6969, 0, 0, 1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        if (i == 0 || !plan[i-1].is_reg) settle();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        push_pixel(plan[i].c, plan[i].dst, plan[i].src, plan[i].msk, plan[i].typed,
                   plan[i].hand);
      end
    end

    while (pixels_sent < BEAT_BUDGET) begin
      settle();
      phases++;
      tx_calm = ($urandom_range(0, 4) == 0);
      mode_pick = ($urandom_range(0, 1) == 0) ? MODE_TILE : merge_mode_t'($urandom_range(0, 2));
      g_across = $urandom_range(1, 4);
      g_down = $urandom_range(1, 4);
      g_width = $urandom_range(1, 4);
      g_height = $urandom_range(1, 3);
      shape = $urandom_range(0, 19);
      case (shape)
        0: begin
          g_across = MAX_ACROSS;
          g_down = MAX_DOWN;
          g_width = 1;
          g_height = 1;
        end
        1: begin
          g_across = 1;
          g_down = 1;
          g_width = MAX_SIDE;
          g_height = $urandom_range(1, 2);
        end
        2: begin
          g_across = $urandom_range(1, 2);
          g_down = 1;
          g_width = 1;
          g_height = MAX_SIDE;
        end
        3: begin
          case ($urandom_range(0, 3))
            0: g_across = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_ACROSS + 1, 31);
            1: g_down = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_DOWN + 1, 31);
            2: g_width = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_SIDE + 1, 2047);
            default: g_height = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_SIDE + 1, 2047);
          endcase
        end
        default: ;
      endcase
      // spare high bits of the write data carry noise; the block keeps only the field
      junk = $urandom;
      write_reg(CFG_MERGE_MODE, {junk[8:0], mode_pick});
      write_reg(CFG_TILES_ACROSS, {junk[14:9], g_across});
      write_reg(CFG_TILES_DOWN, {junk[20:15], g_down});
      write_reg(CFG_TILE_WIDTH, g_width);
      write_reg(CFG_TILE_HEIGHT, g_height);
      if ($urandom_range(0, 9) == 0) write_reg($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI), $urandom);
      npix = g_across * g_down * g_width * g_height;

      if (mode_pick == MODE_TILE && geom_valid() && npix <= FRAME_CAP &&
          $urandom_range(0, 4) != 0) begin
        // whole frame: realign, scan pass with sparse visible pixels, then merge pass
        while (!at_frame_origin()) push_pixel(CMD_SCAN, $urandom, $urandom, $urandom, 0, '0);
        broken = ($urandom_range(0, 7) == 0);
        n = broken ? $urandom_range(1, npix) : npix;
        for (int k = 0; k < n; k++) begin
          src = $urandom;
          if ($urandom_range(0, 7) != 0) src[31:24] = 8'h00;
          push_pixel(CMD_SCAN, $urandom, src, $urandom, 0, '0);
        end
        for (int k = 0; k < npix; k++) begin
          src = $urandom;
          if ($urandom_range(0, 3) != 0) src[31:24] = 8'h00;
          push_pixel(CMD_MERGE, $urandom, src, $urandom, 0, '0);
        end
      end else begin
        n = $urandom_range(4, 40);
        for (int k = 0; k < n; k++) begin
          src = $urandom;
          if ($urandom_range(0, 1) == 0) src[31:24] = 8'h00;
          push_pixel(($urandom_range(0, 3) == 0) ? CMD_SCAN : CMD_MERGE, $urandom, src,
                     $urandom, 0, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (merges_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("summary: %0d pixel beats in, %0d results checked, %0d frame ends, %0d marked",
             pixels_sent, results_seen, frame_ends, marked_hits);
    $display("summary: %0d register writes over %0d random phases, %0d mismatches",
             writes, phases, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/rime_pkg.sv
sv/rime_raster.sv
sv/rime_merge.sv
sv/rgba_image_merge_engine_core.sv
sv/rime_checker.sv
verif/testbench.sv
